@@ sv/srcc_pkg.sv @@
// Package for the sensor reply CRC checker: word types, frame byte positions,
// CRC constants and the sign-magnitude conversion.
// No dependencies.
package srcc_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned IDX_W   = 3;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [VALUE_W-1:0] t_value;

    localparam t_value CRC_INIT = 16'hFFFF;
    localparam t_value CRC_POLY = 16'hA001;

    // Byte positions inside the eight-byte reply.
    localparam t_idx IDX_FIRST   = 3'd0;
    localparam t_idx IDX_HUM_HI  = 3'd2;
    localparam t_idx IDX_HUM_LO  = 3'd3;
    localparam t_idx IDX_TEMP_HI = 3'd4;
    localparam t_idx IDX_TEMP_LO = 3'd5;
    localparam t_idx IDX_CRC_LO  = 3'd6;
    localparam t_idx IDX_CRC_HI  = 3'd7;

    typedef struct packed {
        t_byte data_byte;
        logic  frame_start;
    } t_in_word;

    typedef struct packed {
        logic          crc_ok;
        logic [15:0]   temperature_tenths;
        t_value        humidity_tenths;
    } t_result;

    // Sign-magnitude to two's complement; negative zero gives zero.
    function automatic logic [15:0] sign_mag_to_twos(input t_value raw);
        logic [15:0] mag;
        mag = {1'b0, raw[14:0]};
        return raw[15] ? (16'd0 - mag) : mag;
    endfunction

endpackage

@@ sv/srcc_if.sv @@
// Handshake interfaces for the input byte word and the result word.
// Depends on srcc_pkg.
interface srcc_byte_if;
    logic                valid;
    logic                ready;
    srcc_pkg::t_byte     data_byte;
    logic                frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface srcc_result_if;
    logic                valid;
    logic                ready;
    logic                crc_ok;
    logic signed [15:0]  temperature_tenths;
    srcc_pkg::t_value    humidity_tenths;

    modport source (output valid, output crc_ok, output temperature_tenths,
                    output humidity_tenths, input ready);
    modport sink   (input valid, input crc_ok, input temperature_tenths,
                    input humidity_tenths, output ready);
endinterface

@@ sv/sensor_reply_crc_checker_unit.sv @@
// Sensor reply CRC checker: an accepted byte 7 reaches its result word on
// o_result through the input register, then the result register.
// Throughput one byte per cycle; the result register stalls the input only
// when a held result is not taken and the next staged byte also makes one.
// Reset (i_rst_n low, synchronous) empties both registers, zeroes the byte
// position, pending and held values, and sets the running CRC to all ones.
module sensor_reply_crc_checker_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    srcc_byte_if.sink           i_byte,
    srcc_result_if.source       o_result
);
    import srcc_pkg::*;

    // Input register: one staged byte word.
    logic     r_in_valid;
    t_in_word r_in_word;

    // Result register.
    logic     r_out_valid;
    t_result  r_out;

    logic     has_result;
    t_result  core_result;
    logic     advance;
    logic     in_take;

    // Advance the staged word unless it makes a result and the result
    // register is full and not drained this cycle.
    assign advance = r_in_valid && (!has_result || !r_out_valid || o_result.ready);
    assign in_take = i_byte.valid && i_byte.ready;

    // Accept a new word whenever the stage is empty or moving on.
    assign i_byte.ready = !r_in_valid || advance;

    srcc_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (r_in_word),
        .i_fire       (advance),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    // Payload: load on accept only.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word.data_byte   <= i_byte.data_byte;
            r_in_word.frame_start <= i_byte.frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.crc_ok             = r_out.crc_ok;
    assign o_result.temperature_tenths = signed'(r_out.temperature_tenths);
    assign o_result.humidity_tenths    = r_out.humidity_tenths;

`ifndef SYNTH
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && has_result |=> r_out_valid)
        else $error("result word lost after byte 7");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_word))
        else $error("staged word dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> r_in_valid && has_result && r_out_valid && !o_result.ready)
        else $error("input stalled without a full result register");
`endif

endmodule

@@ sv/srcc_crc_fold.sv @@
// Folds one byte into a CRC-16 (reflected, eight bit steps unrolled).
// Depends on srcc_pkg.
module srcc_crc_fold (
    input  srcc_pkg::t_value i_crc,
    input  srcc_pkg::t_byte  i_data,
    output srcc_pkg::t_value o_crc
);
    import srcc_pkg::*;

    always_comb begin
        t_value c;
        c = i_crc ^ {8'd0, i_data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

@@ sv/srcc_frame_core.sv @@
// Frame state: byte position, running CRC, pending fields and held values.
// Depends on srcc_pkg and srcc_crc_fold.
module srcc_frame_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srcc_pkg::t_in_word i_word,
    input  logic               i_fire,
    output logic               o_has_result,
    output srcc_pkg::t_result  o_result
);
    import srcc_pkg::*;

    t_idx   r_byte_index;
    t_value r_running_crc;
    t_byte  r_crc_low_received;
    t_value r_humidity_pending;
    t_value r_temperature_pending;
    t_value r_held_temperature;
    t_value r_held_humidity;

    t_idx   idx;
    t_value crc_base;
    t_value crc_folded;
    t_value n_running_crc;
    logic   crc_match;
    t_value good_temperature;

    assign idx      = i_word.frame_start ? IDX_FIRST : r_byte_index;
    assign crc_base = (idx == IDX_FIRST) ? CRC_INIT : r_running_crc;

    srcc_crc_fold u_fold (
        .i_crc  (crc_base),
        .i_data (i_word.data_byte),
        .o_crc  (crc_folded)
    );

    // Bytes 6 and 7 carry the CRC and are not folded.
    assign n_running_crc    = (idx < IDX_CRC_LO) ? crc_folded : crc_base;
    assign crc_match        = ({i_word.data_byte, r_crc_low_received} == r_running_crc);
    assign good_temperature = sign_mag_to_twos(r_temperature_pending);

    assign o_has_result = (idx == IDX_CRC_HI);

    always_comb begin
        o_result.crc_ok             = crc_match;
        o_result.temperature_tenths = crc_match ? good_temperature : r_held_temperature;
        o_result.humidity_tenths    = crc_match ? r_humidity_pending : r_held_humidity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index          <= IDX_FIRST;
            r_running_crc         <= CRC_INIT;
            r_crc_low_received    <= '0;
            r_humidity_pending    <= '0;
            r_temperature_pending <= '0;
            r_held_temperature    <= '0;
            r_held_humidity       <= '0;
        end else if (i_fire) begin
            r_byte_index  <= idx + t_idx'(1);
            r_running_crc <= n_running_crc;
            unique case (idx)
                IDX_HUM_HI:  r_humidity_pending[15:8]    <= i_word.data_byte;
                IDX_HUM_LO:  r_humidity_pending[7:0]     <= i_word.data_byte;
                IDX_TEMP_HI: r_temperature_pending[15:8] <= i_word.data_byte;
                IDX_TEMP_LO: r_temperature_pending[7:0]  <= i_word.data_byte;
                IDX_CRC_LO:  r_crc_low_received          <= i_word.data_byte;
                IDX_CRC_HI: begin
                    if (crc_match) begin
                        r_held_temperature <= good_temperature;
                        r_held_humidity    <= r_humidity_pending;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_start_realigns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_word.frame_start |=> r_byte_index == 3'd1)
        else $error("start word did not realign the byte position");

    a_mismatch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_has_result && !crc_match |=>
            $stable(r_held_temperature) && $stable(r_held_humidity))
        else $error("held values changed on a CRC mismatch");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (idx == IDX_CRC_LO || idx == IDX_CRC_HI) |=> $stable(r_running_crc))
        else $error("running CRC changed on a CRC byte");
`endif

endmodule
